### rtl/kdt_pkg.sv
`default_nettype none
package kdt_pkg;

  localparam int TREE_SLOTS  = 1024;
  localparam int QUEUE_SLOTS = 1024;
  localparam int DIMS        = 3;

  localparam int NODE_W  = $clog2(TREE_SLOTS);
  localparam int CHILD_W = $clog2(2 * TREE_SLOTS + 1);
  localparam int QIDX_W  = $clog2(QUEUE_SLOTS);
  localparam int QCNT_W  = QIDX_W + 1;
  localparam int SEQ_W   = $clog2(2 * TREE_SLOTS + 2);
  localparam int KEY_W   = 34;
  localparam int VIS_W   = 10;
  localparam int FIFO_DEPTH = 2;

  localparam logic [VIS_W-1:0] VISIT_MAX     = '1;
  localparam logic [KEY_W-1:0] DIST_ALL_ONES = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_LEAF    = 2'd1;
  localparam logic [1:0] KIND_SPLIT   = 2'd2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } point_t;

  typedef struct packed {
    logic               op;
    logic [9:0]         node_index;
    logic [1:0]         node_type;
    logic [1:0]         split_dim;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } req_t;

  typedef struct packed {
    logic signed [15:0] nearest_x;
    logic signed [15:0] nearest_y;
    logic signed [15:0] nearest_z;
    logic [9:0]         nearest_node;
    logic [33:0]        nearest_distance;
    logic               found;
    logic [9:0]         visited;
    logic               queue_overflow;
  } rsp_t;

  typedef struct packed {
    logic       op;
    logic       in_tree;
    logic [9:0] idx;
    logic [1:0] kind;
    logic [1:0] axis;
    point_t     pt;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] axis;
    point_t     pt;
  } node_t;

  typedef struct packed {
    logic [CHILD_W-1:0] slot;
    logic [KEY_W-1:0]   key;
    logic [SEQ_W-1:0]   seq;
  } pq_entry_t;

  typedef struct packed {
    logic               clear;
    logic               push;
    logic               pop;
    logic [CHILD_W-1:0] slot;
    logic [KEY_W-1:0]   key;
  } pq_cmd_t;

  typedef struct packed {
    logic [QCNT_W-1:0]  count;
    logic               busy;
    logic               done;
    logic [CHILD_W-1:0] slot;
    logic [KEY_W-1:0]   key;
    logic               overflow;
  } pq_stat_t;

  function automatic logic signed [15:0] coord_sel(point_t p, logic [1:0] k);
    logic signed [15:0] r;
    case (k)
      2'd0:    r = p.x;
      2'd1:    r = p.y;
      default: r = p.z;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/kdt_if.sv
`default_nettype none
interface kdt_req_if;
  logic          valid;
  logic          ready;
  kdt_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface kdt_rsp_if;
  logic          valid;
  logic          ready;
  kdt_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/kd_tree_nearest_search.sv
`default_nettype none
// channel | dir | payload                                   | beat accepted when
// req     | in  | op, node_index, node_type, split_dim, xyz  | req.valid && req.ready
// rsp     | out | nearest xyz/node/distance, flags, visited  | rsp.valid && rsp.ready
//
// a node write is done by the back end while it is idle; a query pops the search queue,
// each pop scans the queue, then skips an invalid slot or scores a leaf or split node;
// the linear min scan of the search queue sets the query time
// after reset the node store is cleared, req.ready low throughout
// a two-beat queue sits between the front and the back; a waiting result does not
// stop node writes
module kd_tree_nearest_search (
  input  wire logic clk,
  input  wire logic rst,
  kdt_req_if.sink   req,
  kdt_rsp_if.source rsp
);

  kdt_pkg::cmd_t     cmd;
  logic              cmd_valid;
  logic              cmd_ready;
  logic              open;
  kdt_pkg::pq_cmd_t  pq_cmd;
  kdt_pkg::pq_stat_t pq_stat;

  kdt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .open      (open),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  kdt_pq u_pq (
    .clk  (clk),
    .rst  (rst),
    .cmd  (pq_cmd),
    .stat (pq_stat)
  );

  kdt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .open      (open),
    .pq_cmd    (pq_cmd),
    .pq_stat   (pq_stat),
    .rsp       (rsp)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !open |-> !req.ready) else $error("request taken during store clear");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    pq_stat.count <= kdt_pkg::QCNT_W'(kdt_pkg::QUEUE_SLOTS)) else $error("queue over capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pq_cmd.pop |-> (pq_stat.count != '0) && !pq_stat.busy) else $error("bad pop");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.found |-> rsp.data.nearest_distance == '0 &&
      rsp.data.nearest_node == '0) else $error("empty result not zeroed");

endmodule
`default_nettype wire

### rtl/kdt_front.sv
`default_nettype none
module kdt_front (
  input  wire logic          clk,
  input  wire logic          rst,
  kdt_req_if.sink            req,
  input  wire logic          open,
  output kdt_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);

  kdt_pkg::cmd_t fifo [kdt_pkg::FIFO_DEPTH];
  logic [$clog2(kdt_pkg::FIFO_DEPTH+1)-1:0] count;
  logic [$clog2(kdt_pkg::FIFO_DEPTH)-1:0]   rd_ptr;
  logic [$clog2(kdt_pkg::FIFO_DEPTH)-1:0]   wr_ptr;
  kdt_pkg::cmd_t in_cmd;
  logic push;
  logic pop;

  assign req.ready = open && (count < ($bits(count))'(kdt_pkg::FIFO_DEPTH));
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = fifo[rd_ptr];

  // classify and clamp the axis on the way in
  always_comb begin
    in_cmd.op      = req.data.op;
    in_cmd.in_tree = ({1'b0, req.data.node_index} < 11'(kdt_pkg::TREE_SLOTS));
    in_cmd.idx     = req.data.node_index;
    in_cmd.kind    = req.data.node_type;
    in_cmd.axis    = (req.data.split_dim >= 2'(kdt_pkg::DIMS)) ? 2'(kdt_pkg::DIMS - 1)
                                                               : req.data.split_dim;
    in_cmd.pt.x    = req.data.coord_x;
    in_cmd.pt.y    = req.data.coord_y;
    in_cmd.pt.z    = req.data.coord_z;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/kdt_pq.sv
`default_nettype none
module kdt_pq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire kdt_pkg::pq_cmd_t cmd,
  output kdt_pkg::pq_stat_t  stat
);

  kdt_pkg::pq_entry_t mem [kdt_pkg::QUEUE_SLOTS];
  kdt_pkg::pq_entry_t rdata;
  kdt_pkg::pq_entry_t min_e;
  kdt_pkg::pq_entry_t cand;
  logic [kdt_pkg::QIDX_W-1:0] min_idx;
  logic [kdt_pkg::QIDX_W-1:0] cand_idx;
  logic [kdt_pkg::QIDX_W-1:0] scan_addr;
  logic [kdt_pkg::QIDX_W-1:0] rd_idx;
  logic [kdt_pkg::QIDX_W-1:0] last_idx;
  logic [kdt_pkg::QCNT_W-1:0] count;
  logic [kdt_pkg::SEQ_W-1:0]  seq;
  logic scanning;
  logic rvalid;
  logic done;
  logic overflow;
  logic full;
  logic take;
  logic last_hit;
  logic wr_en;
  logic [kdt_pkg::QIDX_W-1:0] wr_addr;
  kdt_pkg::pq_entry_t wr_data;
  logic [kdt_pkg::CHILD_W-1:0] out_slot;
  logic [kdt_pkg::KEY_W-1:0]   out_key;

  assign full     = (count == kdt_pkg::QCNT_W'(kdt_pkg::QUEUE_SLOTS));
  assign last_idx = kdt_pkg::QIDX_W'(count - 1'b1);
  assign last_hit = rvalid && (rd_idx == last_idx);

  // running minimum; equal keys go to the oldest push
  always_comb begin
    take = (rd_idx == '0) || (rdata.key < min_e.key) ||
           ((rdata.key == min_e.key) && (rdata.seq < min_e.seq));
    cand     = take ? rdata : min_e;
    cand_idx = take ? rd_idx : min_idx;
  end

  // the last entry read fills the hole left by the popped one
  always_comb begin
    wr_en   = last_hit || (cmd.push && !cmd.clear && !full);
    wr_addr = last_hit ? cand_idx : count[kdt_pkg::QIDX_W-1:0];
    wr_data = last_hit ? rdata
                       : kdt_pkg::pq_entry_t'{slot: cmd.slot, key: cmd.key, seq: seq};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (rvalid) begin
      min_e   <= cand;
      min_idx <= cand_idx;
    end
    if (last_hit) begin
      out_slot <= cand.slot;
      out_key  <= cand.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      seq       <= '0;
      overflow  <= 1'b0;
      scanning  <= 1'b0;
      rvalid    <= 1'b0;
      done      <= 1'b0;
      scan_addr <= '0;
      rd_idx    <= '0;
    end else begin
      done   <= !cmd.clear && !cmd.push && last_hit;
      rvalid <= !cmd.pop && scanning;
      if (cmd.clear) begin
        count    <= '0;
        seq      <= '0;
        overflow <= 1'b0;
      end else if (cmd.push) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          count <= count + 1'b1;
          seq   <= seq + 1'b1;
        end
      end else if (last_hit) begin
        count <= count - 1'b1;
      end
      if (cmd.pop) begin
        scanning  <= 1'b1;
        scan_addr <= '0;
      end else if (scanning) begin
        rd_idx <= scan_addr;
        if (scan_addr == last_idx) begin
          scanning <= 1'b0;
        end else begin
          scan_addr <= scan_addr + 1'b1;
        end
      end
    end
  end

  always_comb begin
    stat.count    = count;
    stat.busy     = scanning || rvalid;
    stat.done     = done;
    stat.slot     = out_slot;
    stat.key      = out_key;
    stat.overflow = overflow;
  end

endmodule
`default_nettype wire

### rtl/kdt_engine.sv
`default_nettype none
module kdt_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire kdt_pkg::cmd_t cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  output logic               open,
  output kdt_pkg::pq_cmd_t   pq_cmd,
  input  wire kdt_pkg::pq_stat_t pq_stat,
  kdt_rsp_if.source          rsp
);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_ROOT  = 13'b0000000000100,
    S_POP   = 13'b0000000001000,
    S_POPW  = 13'b0000000010000,
    S_READ  = 13'b0000000100000,
    S_LOOK  = 13'b0000001000000,
    S_MUL   = 13'b0000010000000,
    S_ACC   = 13'b0000100000000,
    S_CMP   = 13'b0001000000000,
    S_PUSHA = 13'b0010000000000,
    S_PUSHB = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state;
  kdt_pkg::node_t node_mem [kdt_pkg::TREE_SLOTS];
  kdt_pkg::node_t node_rd;
  kdt_pkg::node_t node;
  logic [kdt_pkg::NODE_W-1:0] node_raddr;
  logic [kdt_pkg::NODE_W:0]   clr_addr;
  logic node_we;
  logic [kdt_pkg::NODE_W-1:0] node_waddr;
  kdt_pkg::node_t node_wdata;

  kdt_pkg::point_t qpt;
  kdt_pkg::point_t best_pos;
  logic [kdt_pkg::KEY_W-1:0]   best;
  logic [kdt_pkg::CHILD_W-1:0] best_slot;
  logic [kdt_pkg::CHILD_W-1:0] cur_slot;
  logic [kdt_pkg::KEY_W-1:0]   acc;
  logic [kdt_pkg::KEY_W-1:0]   off2;
  logic [31:0]                 prod;
  logic                        off_pos;
  logic [1:0]                  k;
  logic                        found;
  logic [kdt_pkg::VIS_W-1:0]   visits;
  logic signed [16:0]          diff;
  logic [kdt_pkg::CHILD_W-1:0] child1;
  logic [kdt_pkg::CHILD_W-1:0] child2;
  logic                        near_ok;

  assign open      = (state != S_CLEAR);
  assign cmd_ready = (state == S_IDLE);
  assign child1    = {cur_slot[kdt_pkg::CHILD_W-2:0], 1'b0} + kdt_pkg::CHILD_W'(1);
  assign child2    = {cur_slot[kdt_pkg::CHILD_W-2:0], 1'b0} + kdt_pkg::CHILD_W'(2);
  assign near_ok   = (off2 < best);
  assign diff      = 17'(kdt_pkg::coord_sel(qpt, k)) - 17'(kdt_pkg::coord_sel(node.pt, k));

  always_comb begin
    node_we    = 1'b0;
    node_waddr = cmd.idx[kdt_pkg::NODE_W-1:0];
    node_wdata = '{kind: cmd.kind, axis: cmd.axis, pt: cmd.pt};
    if (state == S_CLEAR) begin
      node_we    = 1'b1;
      node_waddr = clr_addr[kdt_pkg::NODE_W-1:0];
      node_wdata = '0;
    end else if (state == S_IDLE && cmd_valid && cmd.op == kdt_pkg::OP_WRITE && cmd.in_tree) begin
      node_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rd <= node_mem[node_raddr];
  end

  always_comb begin
    pq_cmd = '0;
    case (state)
      S_IDLE:  pq_cmd.clear = cmd_valid && (cmd.op == kdt_pkg::OP_QUERY);
      S_ROOT:  pq_cmd.push  = 1'b1;
      S_POP:   pq_cmd.pop   = (pq_stat.count != '0);
      S_PUSHA: begin
        pq_cmd.slot = child1;
        pq_cmd.push = !off_pos || near_ok;
        pq_cmd.key  = off_pos ? off2 : '0;
      end
      S_PUSHB: begin
        pq_cmd.slot = child2;
        pq_cmd.push = off_pos || near_ok;
        pq_cmd.key  = off_pos ? '0 : off2;
      end
      default: pq_cmd = '0;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        qpt <= cmd.pt;
      end
      S_POPW: begin
        cur_slot   <= pq_stat.slot;
        node_raddr <= pq_stat.slot[kdt_pkg::NODE_W-1:0];
      end
      S_LOOK: begin
        node <= node_rd;
        acc  <= '0;
        k    <= '0;
      end
      S_MUL: begin
        prod <= 32'(diff * diff);
        if (k == node.axis) off_pos <= (diff > 17'sd0);
      end
      S_ACC: begin
        acc <= acc + kdt_pkg::KEY_W'(prod);
        if (k == node.axis) off2 <= kdt_pkg::KEY_W'(prod);
        k <= k + 2'd1;
      end
      S_CMP: begin
        if (acc < best) begin
          best_pos  <= node.pt;
          best_slot <= cur_slot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp.valid <= 1'b0;
      found     <= 1'b0;
      visits    <= '0;
      best      <= kdt_pkg::DIST_ALL_ONES;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (kdt_pkg::NODE_W + 1)'(kdt_pkg::TREE_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid && cmd.op == kdt_pkg::OP_QUERY) begin
            found  <= 1'b0;
            visits <= '0;
            best   <= kdt_pkg::DIST_ALL_ONES;
            state  <= S_ROOT;
          end
        end
        S_ROOT: state <= S_POP;
        S_POP: begin
          state <= (pq_stat.count == '0) ? S_DONE : S_POPW;
        end
        S_POPW: begin
          if (pq_stat.done) begin
            if (pq_stat.key > best) begin
              state <= S_DONE;
            end else if (pq_stat.slot >= kdt_pkg::CHILD_W'(kdt_pkg::TREE_SLOTS)) begin
              state <= S_POP;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_LOOK;
        S_LOOK: begin
          if (node_rd.kind == kdt_pkg::KIND_LEAF || node_rd.kind == kdt_pkg::KIND_SPLIT) begin
            found <= 1'b1;
            state <= S_MUL;
          end else begin
            state <= S_POP;
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: state <= (k == 2'(kdt_pkg::DIMS - 1)) ? S_CMP : S_MUL;
        S_CMP: begin
          if (acc < best) best <= acc;
          state <= (node.kind == kdt_pkg::KIND_SPLIT) ? S_PUSHA : S_POP;
        end
        S_PUSHA: state <= S_PUSHB;
        S_PUSHB: begin
          if (visits != kdt_pkg::VISIT_MAX) visits <= visits + 1'b1;
          state <= S_POP;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.data.nearest_x        <= found ? best_pos.x : '0;
      rsp.data.nearest_y        <= found ? best_pos.y : '0;
      rsp.data.nearest_z        <= found ? best_pos.z : '0;
      rsp.data.nearest_node     <= found ? 10'(best_slot) : '0;
      rsp.data.nearest_distance <= found ? best : '0;
      rsp.data.found            <= found;
      rsp.data.visited          <= visits;
      rsp.data.queue_overflow   <= pq_stat.overflow;
    end
  end

endmodule
`default_nettype wire

### sim/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kdt_req_if req_ch ();
  kdt_rsp_if rsp_ch ();

  kd_tree_nearest_search i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  // mirror of the node store
  logic [1:0]       tree_kind [kdt_pkg::TREE_SLOTS] = '{default: kdt_pkg::KIND_INVALID};
  logic [1:0]       tree_axis [kdt_pkg::TREE_SLOTS];
  kdt_pkg::point_t  tree_pos  [kdt_pkg::TREE_SLOTS];

  // best-bin-first queue of the predictor
  int     bin_slot [2 * kdt_pkg::QUEUE_SLOTS];
  longint bin_key  [2 * kdt_pkg::QUEUE_SLOTS];
  int     bin_seq  [2 * kdt_pkg::QUEUE_SLOTS];
  int     bin_count;
  int     bin_next_seq;
  bit     bin_overflow;

  kdt_pkg::req_t pending_beats [$];
  kdt_pkg::rsp_t expected_results [$];
  bit   failed = 1'b0;
  bit   quiet = 1'b0;
  int   send_gap = 0;
  int   recv_stall = 0;
  int   items_queued = 0;

  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic void bin_push(int slot, longint key);
    if (bin_count >= kdt_pkg::QUEUE_SLOTS) begin
      bin_overflow = 1'b1;
      return;
    end
    bin_slot[bin_count] = slot;
    bin_key[bin_count]  = key;
    bin_seq[bin_count]  = bin_next_seq;
    bin_next_seq++;
    bin_count++;
  endfunction

  function automatic longint sq_dist(kdt_pkg::point_t a, kdt_pkg::point_t b);
    longint dx, dy, dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic kdt_pkg::rsp_t nearest_lookup(kdt_pkg::req_t q);
    kdt_pkg::rsp_t   r;
    kdt_pkg::point_t p;
    longint best, key, d, off, off2;
    int     best_node, slot, m, visits, ax;
    bit     found;
    p = '{x: q.coord_x, y: q.coord_y, z: q.coord_z};
    bin_count = 0;
    bin_next_seq = 0;
    bin_overflow = 1'b0;
    best = longint'(kdt_pkg::DIST_ALL_ONES);
    best_node = 0;
    visits = 0;
    found = 1'b0;
    bin_push(0, 0);
    while (bin_count > 0) begin
      m = 0;
      for (int i = 1; i < bin_count; i++)
        if (bin_key[i] < bin_key[m] || (bin_key[i] == bin_key[m] && bin_seq[i] < bin_seq[m]))
          m = i;
      slot = bin_slot[m];
      key  = bin_key[m];
      bin_count--;
      bin_slot[m] = bin_slot[bin_count];
      bin_key[m]  = bin_key[bin_count];
      bin_seq[m]  = bin_seq[bin_count];
      if (key > best) break;
      if (slot >= kdt_pkg::TREE_SLOTS) continue;
      if (tree_kind[slot] != kdt_pkg::KIND_LEAF && tree_kind[slot] != kdt_pkg::KIND_SPLIT)
        continue;
      found = 1'b1;
      d = sq_dist(tree_pos[slot], p);
      if (d < best) begin
        best = d;
        best_node = slot;
      end
      if (tree_kind[slot] != kdt_pkg::KIND_SPLIT) continue;
      ax = tree_axis[slot];
      off = longint'(kdt_pkg::coord_sel(p, 2'(ax))) -
            longint'(kdt_pkg::coord_sel(tree_pos[slot], 2'(ax)));
      off2 = off * off;
      if (off > 0) begin
        if (off2 < best) bin_push(2 * slot + 1, off2);
        bin_push(2 * slot + 2, 0);
      end else begin
        bin_push(2 * slot + 1, 0);
        if (off2 < best) bin_push(2 * slot + 2, off2);
      end
      if (visits < 1023) visits++;
    end
    r = '0;
    if (found) begin
      r.nearest_x = tree_pos[best_node].x;
      r.nearest_y = tree_pos[best_node].y;
      r.nearest_z = tree_pos[best_node].z;
      r.nearest_node = 10'(best_node);
      r.nearest_distance = 34'(best);
    end
    r.found = found;
    r.visited = 10'(visits);
    r.queue_overflow = bin_overflow;
    return r;
  endfunction

  task automatic report(string field, longint want, longint got);
    if (want != got) begin
      failed = 1'b1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  task automatic queue_item(logic op, int idx, int kind, int dim, int x, int y, int z);
    kdt_pkg::req_t b;
    b.op = op;
    b.node_index = 10'(idx);
    b.node_type = 2'(kind);
    b.split_dim = 2'(dim);
    b.coord_x = 16'(x);
    b.coord_y = 16'(y);
    b.coord_z = 16'(z);
    pending_beats.insert(pending_beats.size(), b);
    items_queued++;
  endtask

  function automatic int rand_coord(int spread);
    case (spread)
      0:       return int'($urandom_range(0, 16)) - 8;
      1:       return int'($urandom_range(0, 2000)) - 1000;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // request side
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (send_gap > 0) begin
        req_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_beats.size() > 0) begin
        req_ch.data <= pending_beats.pop_front();
        req_ch.valid <= 1'b1;
        send_gap <= idle_draw();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response side back-pressure
  always @(posedge clk) begin : resp_ready_blk
    int s;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall > 0) begin
      rsp_ch.ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      s = idle_draw();
      rsp_ch.ready <= (s == 0);
      recv_stall <= (s == 0) ? 0 : s - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // monitor: mirror writes, predict queries, check results
  always @(posedge clk) begin : monitor_blk
    kdt_pkg::rsp_t want, got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.data.op == kdt_pkg::OP_WRITE) begin
          tree_kind[req_ch.data.node_index] <= req_ch.data.node_type;
          tree_axis[req_ch.data.node_index] <=
            (req_ch.data.split_dim >= kdt_pkg::DIMS) ? 2'(kdt_pkg::DIMS - 1)
                                                     : req_ch.data.split_dim;
          tree_pos[req_ch.data.node_index] <=
            '{x: req_ch.data.coord_x, y: req_ch.data.coord_y, z: req_ch.data.coord_z};
        end else begin
          expected_results.insert(expected_results.size(), nearest_lookup(req_ch.data));
        end
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (expected_results.size() == 0) begin
          failed = 1'b1;
          $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
        end else begin
          want = expected_results.pop_front();
          report("nearest_x", want.nearest_x, got.nearest_x);
          report("nearest_y", want.nearest_y, got.nearest_y);
          report("nearest_z", want.nearest_z, got.nearest_z);
          report("nearest_node", want.nearest_node, got.nearest_node);
          report("nearest_distance", want.nearest_distance, got.nearest_distance);
          report("found", want.found, got.found);
          report("visited", want.visited, got.visited);
          report("queue_overflow", want.queue_overflow, got.queue_overflow);
        end
      end
    end
  end

  initial begin
    int depth, n, spread, slot;

    // empty tree, extreme query
    queue_item(kdt_pkg::OP_QUERY, 0, 0, 0, -32768, 32767, -32768);
    // single leaf at the far corner
    queue_item(kdt_pkg::OP_WRITE, 0, kdt_pkg::KIND_LEAF, 0, -32768, 32767, -32768);
    queue_item(kdt_pkg::OP_QUERY, 1023, 3, 3, 32767, -32768, 32767);
    // type three reads as invalid
    queue_item(kdt_pkg::OP_WRITE, 0, 3, 0, 5, 5, 5);
    queue_item(kdt_pkg::OP_QUERY, 0, 0, 0, 5, 5, 5);
    // split on axis 3 falls back to z, tie between equal children
    queue_item(kdt_pkg::OP_WRITE, 0, kdt_pkg::KIND_SPLIT, 3, 0, 0, 0);
    queue_item(kdt_pkg::OP_WRITE, 1, kdt_pkg::KIND_LEAF, 0, 3, 4, -1);
    queue_item(kdt_pkg::OP_WRITE, 2, kdt_pkg::KIND_LEAF, 1, 3, 4, -1);
    queue_item(kdt_pkg::OP_QUERY, 0, 0, 0, 3, 4, 0);
    queue_item(kdt_pkg::OP_QUERY, 0, 0, 0, 3, 4, -1);
    // chain of splits down to the last slots, children beyond the tree
    slot = 0;
    while (slot < kdt_pkg::TREE_SLOTS) begin
      queue_item(kdt_pkg::OP_WRITE, slot, kdt_pkg::KIND_SPLIT, slot % 3, slot, -slot, slot);
      slot = 2 * slot + 2;
    end
    queue_item(kdt_pkg::OP_WRITE, 511, kdt_pkg::KIND_SPLIT, 2, 1, 1, 1);
    queue_item(kdt_pkg::OP_WRITE, 1023, kdt_pkg::KIND_LEAF, 0, 32767, 32767, 32767);
    queue_item(kdt_pkg::OP_QUERY, 0, 0, 0, 2000, -2000, 2000);
    queue_item(kdt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);

    while (items_queued < 1775) begin
      depth = $urandom_range(1, 6);
      n = (1 << depth) - 1;
      spread = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0)
          queue_item(kdt_pkg::OP_WRITE, i, $urandom_range(0, 1) ? 3 : kdt_pkg::KIND_INVALID,
                     $urandom_range(0, 3),
                     rand_coord(spread), rand_coord(spread), rand_coord(spread));
        else
          queue_item(kdt_pkg::OP_WRITE, i,
                     (i >= n / 2) ? kdt_pkg::KIND_LEAF : kdt_pkg::KIND_SPLIT,
                     $urandom_range(0, 3),
                     rand_coord(spread), rand_coord(spread), rand_coord(spread));
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4))
          queue_item(kdt_pkg::OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 3),
                     $urandom_range(0, 3), rand_coord(2), rand_coord(2), rand_coord(2));
      repeat ($urandom_range(3, 8))
        queue_item(kdt_pkg::OP_QUERY, $urandom_range(0, 1023), $urandom_range(0, 3),
                   $urandom_range(0, 3), rand_coord(spread), rand_coord(spread),
                   rand_coord(spread));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_beats.size() > 0 || req_ch.valid) begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) quiet = ~quiet;
    end
    while (expected_results.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
